// File: rtl/llqm_pkg.sv
// ----------------------------------------------------------------------------
// Linked-list queue manager package
// Shared request, response and holder types, status codes and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package llqm_pkg;

  // Operation codes carried in the opcode field of a request.
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_DATA   = 2'd1,
    STATUS_POOL_EMPTY = 2'd2,
    STATUS_LIST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  list_sel;
    logic        has_data;
    logic        data_id_ok;
    logic [15:0] data_ref;
    logic [15:0] msg_code;
    logic [15:0] data_len;
    logic [7:0]  prio;
    logic [15:0] origin_tag;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] out_msg_code;
    logic [15:0] out_data_ref;
    logic        out_data_ok;
    logic [15:0] out_data_len;
    logic [7:0]  out_prio;
    logic [15:0] out_origin;
  } rsp_t;

  // Message fields kept in one holder of the pool.
  typedef struct packed {
    logic [15:0] msg_code;
    logic [15:0] data_ref;
    logic        data_ok;
    logic [15:0] data_len;
    logic [7:0]  prio;
    logic [15:0] origin;
  } slot_t;

  // Controller to datapath.
  typedef struct packed {
    logic clr_step;  // write one entry of the free-list chain after reset
    logic capture;   // request accepted: latch it and start the memory reads
    logic commit;    // update the lists, write the memories, load the response
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic init_done;
  } sts_t;

endpackage

// File: rtl/llqm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module llqm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/llqm_ctrl.sv
// ----------------------------------------------------------------------------
// Linked-list queue manager controller
// Sequences the clearing pass, request capture and commit, and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module llqm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  llqm_pkg::sts_t sts_i,
  output llqm_pkg::cmd_t cmd_o
);

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.clr_step = ~sts_i.init_done;
        if (sts_i.init_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The response register must be free, or be emptied this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/llqm_dp.sv
// ----------------------------------------------------------------------------
// Linked-list queue manager datapath
// List head and tail registers, free-list head, link and holder memories and
// the response register.
// ----------------------------------------------------------------------------
module llqm_dp #(
  parameter int unsigned POOL_DEPTH = 256,
  parameter int unsigned NUM_LISTS  = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  llqm_pkg::cmd_t cmd_i,
  output llqm_pkg::sts_t sts_o,
  input  llqm_pkg::req_t in_i,
  output llqm_pkg::rsp_t out_o
);

  localparam int unsigned LW         = $clog2(POOL_DEPTH + 1);
  localparam int unsigned IW         = $clog2(POOL_DEPTH);
  localparam int unsigned SW         = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int unsigned LIST_SLOTS = 1 << SW;
  localparam int unsigned SLOT_W     = $bits(llqm_pkg::slot_t);
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);

  logic [LW-1:0]   head_q [LIST_SLOTS];
  logic [LW-1:0]   head_d [LIST_SLOTS];
  logic [LW-1:0]   tail_q [LIST_SLOTS];
  logic [LW-1:0]   tail_d [LIST_SLOTS];
  logic [LW-1:0]   free_q, free_d;
  logic [LW-1:0]   clr_cnt_q;
  llqm_pkg::req_t  req_q;
  llqm_pkg::rsp_t  rsp_q, rsp_d;

  logic [SW+1:0]   in_sel_ext, q_sel_ext;
  logic [SW-1:0]   in_sel, sel_q;
  logic            in_sel_ok, sel_ok_q;
  logic [LW-1:0]   rd_link, h_link, t_link;

  logic            link_we, link_cwe;
  logic [IW-1:0]   link_waddr, link_cwaddr;
  logic [LW-1:0]   link_wdata, link_cwdata, link_rdata;
  logic            next_valid;
  logic            slot_we;
  llqm_pkg::slot_t slot_wdata, slot_rd;
  logic [SLOT_W-1:0] slot_rdata;
  logic            add_ok, rem_ok;

  // List selection, for the request at the port and for the latched one.
  assign in_sel_ext = (SW + 2)'(in_i.list_sel);
  assign in_sel     = in_sel_ext[SW-1:0];
  assign in_sel_ok  = in_sel_ext < (SW + 2)'(NUM_LISTS);
  assign q_sel_ext  = (SW + 2)'(req_q.list_sel);
  assign sel_q      = q_sel_ext[SW-1:0];
  assign sel_ok_q   = q_sel_ext < (SW + 2)'(NUM_LISTS);

  // A remove reads the head holder, an add reads the free-list head.
  always_comb begin
    if (in_i.opcode == llqm_pkg::OP_REMOVE) begin
      rd_link = in_sel_ok ? head_q[in_sel] : NULL_LINK;
    end else begin
      rd_link = free_q;
    end
  end

  assign h_link     = (req_q.opcode == llqm_pkg::OP_REMOVE) ? head_q[sel_q] : free_q;
  assign t_link     = tail_q[sel_q];
  assign next_valid = link_rdata < NULL_LINK;
  assign slot_rd    = llqm_pkg::slot_t'(slot_rdata);

  always_comb begin
    slot_wdata.msg_code = req_q.msg_code;
    slot_wdata.data_ref = req_q.data_ref;
    slot_wdata.data_ok  = req_q.data_id_ok;
    slot_wdata.data_len = req_q.data_len;
    slot_wdata.prio     = req_q.prio;
    slot_wdata.origin   = req_q.origin_tag;
  end

  // Outcome of the latched request.
  always_comb begin
    add_ok       = 1'b0;
    rem_ok       = 1'b0;
    rsp_d        = '0;
    rsp_d.status = llqm_pkg::STATUS_OK;
    priority if (!sel_ok_q) begin
      rsp_d.status = llqm_pkg::STATUS_LIST_EMPTY;
    end else if (req_q.opcode == llqm_pkg::OP_ADD) begin
      priority if (req_q.has_data && !req_q.data_id_ok) begin
        rsp_d.status = llqm_pkg::STATUS_BAD_DATA;
      end else if (!(free_q < NULL_LINK)) begin
        rsp_d.status = llqm_pkg::STATUS_POOL_EMPTY;
      end else begin
        add_ok = 1'b1;
      end
    end else begin
      if (!(h_link < NULL_LINK)) begin
        rsp_d.status = llqm_pkg::STATUS_LIST_EMPTY;
      end else begin
        rem_ok             = 1'b1;
        rsp_d.out_msg_code = slot_rd.msg_code;
        rsp_d.out_data_ref = slot_rd.data_ref;
        rsp_d.out_data_ok  = slot_rd.data_ok;
        rsp_d.out_data_len = slot_rd.data_len;
        rsp_d.out_prio     = slot_rd.prio;
        rsp_d.out_origin   = slot_rd.origin;
      end
    end
  end

  // The tail holder's link is left stale: the end of a list is found by
  // comparing head and tail, so an add needs only one link write.
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    free_d      = free_q;
    link_cwe    = 1'b0;
    link_cwaddr = h_link[IW-1:0];
    link_cwdata = free_q;
    slot_we     = 1'b0;
    if (cmd_i.commit && add_ok) begin
      free_d  = next_valid ? link_rdata : NULL_LINK;
      slot_we = 1'b1;
      if (t_link < NULL_LINK) begin
        link_cwe    = 1'b1;
        link_cwaddr = t_link[IW-1:0];
        link_cwdata = h_link;
      end else begin
        head_d[sel_q] = h_link;
      end
      tail_d[sel_q] = h_link;
    end else if (cmd_i.commit && rem_ok) begin
      if ((h_link == t_link) || !next_valid) begin
        head_d[sel_q] = NULL_LINK;
        tail_d[sel_q] = NULL_LINK;
      end else begin
        head_d[sel_q] = link_rdata;
      end
      link_cwe    = 1'b1;
      link_cwaddr = h_link[IW-1:0];
      link_cwdata = free_q;
      free_d      = h_link;
    end
  end

  // The clearing pass chains holder i to holder i+1; the last one gets null.
  assign link_we    = cmd_i.clr_step | link_cwe;
  assign link_waddr = cmd_i.clr_step ? clr_cnt_q[IW-1:0] : link_cwaddr;
  assign link_wdata = cmd_i.clr_step ? LW'(clr_cnt_q + 1'b1) : link_cwdata;

  assign sts_o.init_done = (clr_cnt_q == NULL_LINK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LIST_SLOTS; i++) begin
        head_q[i] <= NULL_LINK;
        tail_q[i] <= NULL_LINK;
      end
      free_q    <= '0;
      clr_cnt_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      free_q <= free_d;
      if (cmd_i.clr_step) begin
        clr_cnt_q <= LW'(clr_cnt_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_i;
    end
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_o = rsp_q;

  llqm_ram #(
    .WIDTH (LW),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (rd_link[IW-1:0]),
    .rdata_o (link_rdata)
  );

  llqm_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (POOL_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (h_link[IW-1:0]),
    .wdata_i (slot_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (rd_link[IW-1:0]),
    .rdata_o (slot_rdata)
  );

  // Requests are only taken once the free-list chain is complete.
  a_capture_after_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |-> sts_o.init_done)
    else $error("request captured during the clearing pass");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.clr_step, cmd_i.capture, cmd_i.commit}))
    else $error("more than one datapath command at once");

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= NULL_LINK)
    else $error("free-list head is neither a holder nor null");

  a_head_tail_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && sel_ok_q) |-> ((head_q[sel_q] == NULL_LINK) ==
                                    (tail_q[sel_q] == NULL_LINK)))
    else $error("list head and tail disagree on emptiness");

  a_remove_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && rem_ok) |=> (free_q == $past(h_link)))
    else $error("removed holder not returned to the free list");

endmodule

// File: rtl/linked_list_queue_manager_unit.sv
// ----------------------------------------------------------------------------
// Linked-list queue manager
// Several FIFO message lists sharing one pool of linked holders and a single
// free list, with add-to-tail and remove-from-head requests.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   in        input      in_valid_i / in_ready_o   in_i  (llqm_pkg::req_t)
//   out       output     out_valid_o / out_ready_i out_o (llqm_pkg::rsp_t)
//
// Each request is handled in a read step and a commit step: the read step reads
// the link and holder memories at the list head or free-list head, the commit
// step writes back a link and the holder and loads the response register.
// After reset a clearing pass chains every holder into the free list;
// in_ready_o stays low until it has finished.
// A response waiting in the output register does not stop the next request
// being taken; the commit of that request waits until the register is free.
//
module linked_list_queue_manager_unit #(
  parameter int unsigned POOL_DEPTH = 256,
  parameter int unsigned NUM_LISTS  = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  llqm_pkg::req_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output llqm_pkg::rsp_t out_o
);

  // Commands and status between the sequencer and the datapath.
  llqm_pkg::cmd_t cmd;
  llqm_pkg::sts_t sts;

  // The controller owns both handshakes and steps each request through its
  // read cycle and its commit cycle.
  llqm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the list pointers, the free-list head, both pool
  // memories and the response register.
  llqm_dp #(
    .POOL_DEPTH (POOL_DEPTH),
    .NUM_LISTS  (NUM_LISTS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

// File: dv/llqm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked-list queue manager checker
// Watches both channels of the queue manager, keeps its own copy of the lists,
// the free list and the holder pool, and compares every response with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module llqm_checker #(
  parameter int unsigned POOL_DEPTH = 256,
  parameter int unsigned NUM_LISTS  = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  llqm_pkg::req_t in_req_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  llqm_pkg::rsp_t out_rsp_i,
  output int             fail_cnt_o,
  output int             pending_o
);

  localparam int unsigned LINK_W = $clog2(POOL_DEPTH + 1);
  typedef logic [LINK_W-1:0] link_t;
  localparam link_t NIL_LINK = link_t'(POOL_DEPTH);

  link_t           head_link[NUM_LISTS];
  link_t           tail_link[NUM_LISTS];
  link_t           free_link;
  link_t           next_link_q[POOL_DEPTH];
  llqm_pkg::slot_t holder_q[POOL_DEPTH];
  llqm_pkg::rsp_t  due_rsps[$];
  int              rsp_seen = 0;

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  // Carries out one request on the private copy of the pool and returns the
  // response the block owes for it.
  function automatic llqm_pkg::rsp_t apply_request(llqm_pkg::req_t r);
    llqm_pkg::rsp_t rsp;
    link_t          h;
    int unsigned    sel;
    rsp        = '0;
    rsp.status = llqm_pkg::STATUS_OK;
    sel        = r.list_sel;
    if (sel >= NUM_LISTS) begin
      rsp.status = llqm_pkg::STATUS_LIST_EMPTY;
    end else if (r.opcode == llqm_pkg::OP_ADD) begin
      if (r.has_data && !r.data_id_ok) begin
        rsp.status = llqm_pkg::STATUS_BAD_DATA;
      end else if (free_link >= POOL_DEPTH) begin
        rsp.status = llqm_pkg::STATUS_POOL_EMPTY;
      end else begin
        h         = free_link;
        free_link = (next_link_q[h] < POOL_DEPTH) ? next_link_q[h] : NIL_LINK;
        if (tail_link[sel] < POOL_DEPTH) begin
          next_link_q[tail_link[sel]] = h;
        end else begin
          head_link[sel] = h;
        end
        tail_link[sel]    = h;
        next_link_q[h]    = NIL_LINK;
        holder_q[h].msg_code = r.msg_code;
        holder_q[h].data_ref = r.data_ref;
        holder_q[h].data_ok  = r.data_id_ok;
        holder_q[h].data_len = r.data_len;
        holder_q[h].prio     = r.prio;
        holder_q[h].origin   = r.origin_tag;
      end
    end else begin
      h = head_link[sel];
      if (h >= POOL_DEPTH) begin
        rsp.status = llqm_pkg::STATUS_LIST_EMPTY;
      end else begin
        rsp.out_msg_code = holder_q[h].msg_code;
        rsp.out_data_ref = holder_q[h].data_ref;
        rsp.out_data_ok  = holder_q[h].data_ok;
        rsp.out_data_len = holder_q[h].data_len;
        rsp.out_prio     = holder_q[h].prio;
        rsp.out_origin   = holder_q[h].origin;
        head_link[sel] = (next_link_q[h] < POOL_DEPTH) ? next_link_q[h] : NIL_LINK;
        if (head_link[sel] == NIL_LINK) begin
          tail_link[sel] = NIL_LINK;
        end
        next_link_q[h] = free_link;
        free_link      = h;
      end
    end
    return rsp;
  endfunction

  task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
    fail_cnt_o++;
    if (fail_cnt_o <= 10) begin
      $display("%0t: response %0d, %s: expected %h, got %h",
               $realtime, rsp_seen, field, want, got);
    end
  endtask

  // Responses are handled before requests, so a request taken at the same edge
  // can never be matched against the response leaving at that edge.
  always @(posedge clk_i or negedge rst_ni) begin
    llqm_pkg::rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        head_link[i] = NIL_LINK;
        tail_link[i] = NIL_LINK;
      end
      for (int i = 0; i < POOL_DEPTH; i++) begin
        next_link_q[i] = link_t'(i + 1);
        holder_q[i]    = '0;
      end
      free_link = '0;
      due_rsps.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        rsp_seen++;
        if (due_rsps.size() == 0) begin
          report_mismatch("unexpected response", 16'h0, 16'(out_rsp_i.status));
        end else begin
          want = due_rsps.pop_front();
          if (out_rsp_i.status !== want.status)
            report_mismatch("status", 16'(want.status), 16'(out_rsp_i.status));
          if (out_rsp_i.out_msg_code !== want.out_msg_code)
            report_mismatch("out_msg_code", want.out_msg_code, out_rsp_i.out_msg_code);
          if (out_rsp_i.out_data_ref !== want.out_data_ref)
            report_mismatch("out_data_ref", want.out_data_ref, out_rsp_i.out_data_ref);
          if (out_rsp_i.out_data_ok !== want.out_data_ok)
            report_mismatch("out_data_ok", 16'(want.out_data_ok), 16'(out_rsp_i.out_data_ok));
          if (out_rsp_i.out_data_len !== want.out_data_len)
            report_mismatch("out_data_len", want.out_data_len, out_rsp_i.out_data_len);
          if (out_rsp_i.out_prio !== want.out_prio)
            report_mismatch("out_prio", 16'(want.out_prio), 16'(out_rsp_i.out_prio));
          if (out_rsp_i.out_origin !== want.out_origin)
            report_mismatch("out_origin", want.out_origin, out_rsp_i.out_origin);
        end
      end
      if (in_valid_i && in_ready_i) begin
        due_rsps.push_back(apply_request(in_req_i));
      end
      pending_o = due_rsps.size();
    end
  end

endmodule

// File: dv/linked_list_queue_manager_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked-list queue manager testbench
// Drives add and remove requests into the queue manager with random idling on
// both channels and leaves prediction and comparison to the checker beside it.
// ----------------------------------------------------------------------------
module linked_list_queue_manager_unit_tb;

  localparam int unsigned POOL_DEPTH = 256;
  localparam int unsigned NUM_LISTS  = 4;

  // The slowest correct run is roughly 950 requests plus the clearing pass,
  // some 350 us; the limit allows ten times that.
  localparam int unsigned RUN_LIMIT_NS = 4_000_000;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid;
  logic           in_ready;
  llqm_pkg::req_t in_req;
  logic           out_valid;
  logic           out_ready;
  llqm_pkg::rsp_t out_rsp;
  int             fail_cnt;
  int             pending_cnt;

  // When clear, neither side inserts idle cycles.
  bit   idle_en;

  linked_list_queue_manager_unit #(
    .POOL_DEPTH(POOL_DEPTH),
    .NUM_LISTS (NUM_LISTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_rsp)
  );

  llqm_checker #(
    .POOL_DEPTH(POOL_DEPTH),
    .NUM_LISTS (NUM_LISTS)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_req_i   (in_req),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_i  (out_rsp),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or loses a response.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Builds a request whose wide payload fields all carry one word and whose
  // priority carries one byte; used by the directed part.
  function automatic llqm_pkg::req_t build_request(logic op, logic [1:0] sel, logic has,
                                                   logic ok, logic [15:0] word,
                                                   logic [7:0] byte_val);
    llqm_pkg::req_t r;
    r.opcode     = op;
    r.list_sel   = sel;
    r.has_data   = has;
    r.data_id_ok = ok;
    r.data_ref   = word;
    r.msg_code   = word;
    r.data_len   = word;
    r.prio       = byte_val;
    r.origin_tag = word;
    return r;
  endfunction

  // A random request that is an add with the given percentage. Most adds carry
  // a valid data id so that the lists actually fill; roughly one in sixteen
  // is refused for invalid data.
  function automatic llqm_pkg::req_t rand_request(int unsigned add_pct);
    llqm_pkg::req_t r;
    r.opcode     = ($urandom_range(0, 99) < add_pct) ? llqm_pkg::OP_ADD : llqm_pkg::OP_REMOVE;
    r.list_sel   = 2'($urandom_range(0, 3));
    r.has_data   = 1'($urandom);
    r.data_id_ok = ($urandom_range(0, 7) != 0);
    r.data_ref   = 16'($urandom);
    r.msg_code   = 16'($urandom);
    r.data_len   = 16'($urandom);
    r.prio       = 8'($urandom);
    r.origin_tag = 16'($urandom);
    return r;
  endfunction

  // Presents one request and returns at the falling edge after it has been
  // taken. Valid stays high between back-to-back requests; when an idle burst
  // is chosen it is lowered at this falling edge and raised again a whole
  // number of cycles later, so the two never share a time step.
  task automatic send_request(llqm_pkg::req_t r);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (!(in_valid && in_ready));
    @(negedge clk_i);
  endtask

  // A stretch of random requests. Idling is re-drawn every forty requests so
  // that quiet stretches also turn up in the middle of the run.
  task automatic run_random(int unsigned count, int unsigned add_pct, bit allow_idle);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        idle_en = allow_idle && ($urandom_range(0, 4) != 0);
      end
      send_request(rand_request(add_pct));
    end
  endtask

  // The response side: random stall bursts whenever idling is enabled,
  // otherwise always ready.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    in_valid = 1'b0;
    in_req   = '0;
    idle_en  = 1'b1;
    rst_ni   = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The block first runs its clearing pass; in_ready stays
    // low until then, so the first request simply waits for it.
    // A remove from a list that has never been filled reports an empty list.
    send_request(build_request(llqm_pkg::OP_REMOVE, 2'd0, 1'b1, 1'b1,
                               16'($urandom), 8'($urandom)));
    // Data present but untranslatable: refused, nothing is stored.
    send_request(build_request(llqm_pkg::OP_ADD, 2'd0, 1'b1, 1'b0, 16'hffff, 8'hff));
    // Extremes of every payload field on list 0.
    send_request(build_request(llqm_pkg::OP_ADD, 2'd0, 1'b1, 1'b1, 16'hffff, 8'hff));
    send_request(build_request(llqm_pkg::OP_ADD, 2'd0, 1'b0, 1'b0, 16'h0000, 8'h00));
    // No data block but a valid id: the flag must still be kept and returned.
    send_request(build_request(llqm_pkg::OP_ADD, 2'd0, 1'b0, 1'b1, 16'ha5a5, 8'h5a));
    send_request(build_request(llqm_pkg::OP_ADD, 2'd3, 1'b1, 1'b1, 16'h1234, 8'h80));
    send_request(build_request(llqm_pkg::OP_ADD, 2'd1, 1'b0, 1'b0, 16'h5a5a, 8'ha5));
    // Refused add on a list that stays empty.
    send_request(build_request(llqm_pkg::OP_ADD, 2'd2, 1'b1, 1'b0, 16'h8001, 8'h7f));
    // Drain list 0 in order, one remove beyond its end.
    repeat (4) begin
      send_request(build_request(llqm_pkg::OP_REMOVE, 2'd0, 1'b1, 1'b1,
                                 16'($urandom), 8'($urandom)));
    end
    send_request(build_request(llqm_pkg::OP_REMOVE, 2'd3, 1'b0, 1'b0,
                               16'($urandom), 8'($urandom)));
    send_request(build_request(llqm_pkg::OP_REMOVE, 2'd3, 1'b0, 1'b0,
                               16'($urandom), 8'($urandom)));
    send_request(build_request(llqm_pkg::OP_REMOVE, 2'd1, 1'b0, 1'b1,
                               16'($urandom), 8'($urandom)));
    send_request(build_request(llqm_pkg::OP_REMOVE, 2'd2, 1'b1, 1'b0,
                               16'($urandom), 8'($urandom)));
    // A holder just returned to the free list is taken again straight away.
    send_request(build_request(llqm_pkg::OP_ADD, 2'd2, 1'b1, 1'b1, 16'h7ffe, 8'h01));
    send_request(build_request(llqm_pkg::OP_REMOVE, 2'd2, 1'b0, 1'b0,
                               16'($urandom), 8'($urandom)));

    // Mixed traffic with a slight bias towards adds, so lists grow and shrink.
    run_random(240, 55, 1'b1);
    // Adds only: enough to use up the whole pool and hit the exhausted case
    // repeatedly, with holders scattered by the earlier frees.
    run_random(290, 100, 1'b1);
    // Mostly removes: every list is emptied and then removes run dry.
    run_random(330, 5, 1'b1);
    // Last stretch with no idling on either side.
    run_random(80, 50, 1'b0);
    idle_en = 1'b0;
    in_valid <= 1'b0;

    // Wait for every predicted response, then let the clock run on so that any
    // stray response would still be caught by the checker.
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: linked_list_queue_manager_unit.f
rtl/llqm_pkg.sv
rtl/llqm_ram.sv
rtl/llqm_ctrl.sv
rtl/llqm_dp.sv
rtl/linked_list_queue_manager_unit.sv
dv/llqm_checker.sv
dv/linked_list_queue_manager_unit_tb.sv
